>>> hdl/rcsd_pkg.sv
// Shared types, constants and context-update functions of the chunk stream demultiplexer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rcsd_pkg;

  localparam int unsigned CSID_W      = 17;
  localparam int unsigned LEN_W       = 24;
  localparam int unsigned TS_W        = 32;
  localparam int unsigned CNT_W       = 11;
  localparam int unsigned CAP_W       = 32;
  localparam logic [CNT_W-1:0]  HS_BLOCK   = 11'd1536;
  localparam logic [CSID_W-1:0] CSID_OFS   = 17'd64;
  localparam logic [LEN_W-1:0]  LEN_MAX    = 24'hFFFFFF;
  localparam logic [LEN_W-1:0]  CHUNK_RST  = 24'd128;
  localparam logic [7:0]        TYPE_SET_CHUNK = 8'd1;

  // Parser phases, one-hot.
  typedef enum logic [7:0] {
    PH_VER   = 8'b0000_0001,
    PH_C1    = 8'b0000_0010,
    PH_C2    = 8'b0000_0100,
    PH_BASIC = 8'b0000_1000,
    PH_CSID  = 8'b0001_0000,
    PH_MSG   = 8'b0010_0000,
    PH_PAY   = 8'b0100_0000,
    PH_BEGIN = 8'b1000_0000
  } phase_e;

  // Chunk header formats.
  typedef enum logic [1:0] {
    FMT_FULL  = 2'd0,
    FMT_NOSID = 2'd1,
    FMT_TS    = 2'd2,
    FMT_NONE  = 2'd3
  } fmt_e;

  // Per-stream context as held in the table.
  typedef struct packed {
    logic [TS_W-1:0]  ts;
    logic [LEN_W-1:0] delta;
    logic [LEN_W-1:0] len;
    logic [7:0]       typ;
    logic [31:0]      msid;
    logic [LEN_W-1:0] rcvd;
  } ctx_t;

  // Requests from the parser to the context store.
  typedef struct packed {
    logic sw;
    logic upd;
  } ctx_ctl_t;

  typedef struct packed {
    ctx_t             ctx;
    logic             empty;
    logic [LEN_W-1:0] left;
  } begin_res_t;

  // Message header length in bytes for each format.
  function automatic logic [3:0] hdr_len(fmt_e fmt);
    logic [3:0] n;
    unique case (fmt)
      FMT_FULL:  n = 4'd11;
      FMT_NOSID: n = 4'd7;
      FMT_TS:    n = 4'd3;
      default:   n = 4'd0;
    endcase
    return n;
  endfunction

  // Applies a completed chunk header to the stream context.
  function automatic begin_res_t begin_chunk(ctx_t c, fmt_e fmt, logic [LEN_W-1:0] ts_f,
                                             logic [LEN_W-1:0] len_f, logic [7:0] typ_f,
                                             logic [31:0] msid_f, logic [LEN_W-1:0] active);
    begin_res_t r;
    logic [LEN_W-1:0] rl;
    r.ctx = c;
    unique case (fmt)
      FMT_FULL: begin
        r.ctx.ts   = TS_W'(ts_f);
        r.ctx.len  = len_f;
        r.ctx.typ  = typ_f;
        r.ctx.msid = msid_f;
      end
      FMT_NOSID: begin
        r.ctx.delta = ts_f;
        r.ctx.ts    = c.ts + TS_W'(ts_f);
        r.ctx.len   = len_f;
        r.ctx.typ   = typ_f;
      end
      FMT_TS: begin
        r.ctx.delta = ts_f;
        r.ctx.ts    = c.ts + TS_W'(ts_f);
      end
      default: begin
        if (c.rcvd == '0) begin
          r.ctx.ts = c.ts + TS_W'(c.delta);
        end
      end
    endcase
    rl      = r.ctx.len - r.ctx.rcvd;
    r.empty = (r.ctx.rcvd >= r.ctx.len);
    r.left  = (rl > active) ? active : rl;
    if (r.empty) begin
      r.ctx.rcvd = '0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hdl/rcsd_if.sv
// Valid/ready channel interfaces for the inbound byte stream and the tagged payload.
// Depends on rcsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface rcsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface rcsd_out_if import rcsd_pkg::*;;
  logic              valid;
  logic              ready;
  logic              payload_valid;
  logic [7:0]        payload_byte;
  logic [CSID_W-1:0] chunk_stream_id;
  logic [7:0]        message_type;
  logic [TS_W-1:0]   message_timestamp;
  logic [31:0]       msg_stream_id;
  logic [LEN_W-1:0]  msg_length;
  logic              last_of_message;
  logic              stream_folded;
  modport source (output valid, output payload_valid, output payload_byte,
                  output chunk_stream_id, output message_type, output message_timestamp,
                  output msg_stream_id, output msg_length, output last_of_message,
                  output stream_folded, input ready);
  modport sink (input valid, input payload_valid, input payload_byte,
                input chunk_stream_id, input message_type, input message_timestamp,
                input msg_stream_id, input msg_length, input last_of_message,
                input stream_folded, output ready);
endinterface

`default_nettype wire

>>> hdl/rcsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rcsd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> hdl/rcsd_ctx_store.sv
// Per-stream context table: RAM, one-entry working cache, write-back and clearing pass.
// Depends on rcsd_pkg and rcsd_ram.
`timescale 1ns / 1ps
`default_nettype none

module rcsd_ctx_store import rcsd_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire ctx_ctl_t                       ctl_i,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0] slot_i,
  input  wire ctx_t                           upd_ctx_i,
  output ctx_t                                ctx_o,
  output logic                                busy_o
);

  localparam int unsigned SLOT_W = $clog2(TABLE_DEPTH);

  ctx_t              cache_q, cache_d, rdata;
  logic [SLOT_W-1:0] cache_slot_q, cache_slot_d;
  logic              cache_vld_q, cache_vld_d;
  logic              load_pend_q, load_pend_d;
  logic              clr_busy_q, clr_busy_d;
  logic [SLOT_W-1:0] clr_idx_q, clr_idx_d;
  logic              we;
  logic [SLOT_W-1:0] waddr;
  ctx_t              wdata;
  logic              hit;

  // The working context comes straight from the RAM in the cycle after a load.
  assign ctx_o  = load_pend_q ? rdata : cache_q;
  assign busy_o = clr_busy_q;
  assign hit    = cache_vld_q && (slot_i == cache_slot_q);

  // Switching to an uncached stream writes the old entry back and reads the new one.
  always_comb begin
    cache_d      = cache_q;
    cache_slot_d = cache_slot_q;
    cache_vld_d  = cache_vld_q;
    load_pend_d  = 1'b0;
    clr_busy_d   = clr_busy_q;
    clr_idx_d    = clr_idx_q;
    we           = 1'b0;
    waddr        = cache_slot_q;
    wdata        = ctx_o;
    if (ctl_i.upd) begin
      cache_d = upd_ctx_i;
    end else if (load_pend_q) begin
      cache_d = rdata;
    end
    if (clr_busy_q) begin
      we        = 1'b1;
      waddr     = clr_idx_q;
      wdata     = '0;
      clr_idx_d = clr_idx_q + 1'b1;
      if (clr_idx_q == SLOT_W'(TABLE_DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end
    end else if (ctl_i.sw && !hit) begin
      we           = cache_vld_q;
      load_pend_d  = 1'b1;
      cache_slot_d = slot_i;
      cache_vld_d  = 1'b1;
    end
  end

  rcsd_ram #(
    .WIDTH ($bits(ctx_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (slot_i),
    .rdata_o (rdata)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cache_vld_q <= 1'b0;
      load_pend_q <= 1'b0;
      clr_busy_q  <= 1'b1;
      clr_idx_q   <= '0;
    end else begin
      cache_vld_q <= cache_vld_d;
      load_pend_q <= load_pend_d;
      clr_busy_q  <= clr_busy_d;
      clr_idx_q   <= clr_idx_d;
    end
  end

  // Cache payload.
  always_ff @(posedge clk_i) begin
    cache_q      <= cache_d;
    cache_slot_q <= cache_slot_d;
  end

  // No stream switch is requested while a load is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni) load_pend_q |-> !ctl_i.sw)
    else $error("stream switch during pending load");
  // No stream switch is requested while the table is being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni) clr_busy_q |-> !ctl_i.sw)
    else $error("stream switch during clearing pass");
  // A load always targets a valid cache entry afterwards.
  assert property (@(posedge clk_i) disable iff (!rst_ni) load_pend_q |-> cache_vld_q)
    else $error("load without valid cache entry");

endmodule

`default_nettype wire

>>> hdl/rtmp_chunk_demux_unit.sv
// Top level of the chunk stream demultiplexer: byte parser, slot folding and output register.
// Depends on rcsd_pkg, rcsd_if and rcsd_ctx_store.
`timescale 1ns / 1ps
`default_nettype none

// Takes one connection byte per cycle. After reset the per-stream table is cleared,
// during which no byte is taken; the 3073 handshake bytes are then skipped and
// chunks are parsed. Every format-3 chunk passes through the BEGIN phase after its
// basic header (of one, two or three bytes), in which no byte is taken and the stored
// context of the stream (read from the table RAM through its registered read port
// when the stream changes) is brought up to date before the chunk starts; all other
// bytes pass at one per cycle. Every payload byte and every empty-message end leaves
// through the output register with its stream context in the cycle after it is formed;
// while a result waits there and the receiver does not take it, no byte is taken.
module rtmp_chunk_demux_unit import rcsd_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [LEN_W-1:0] cfg_data_i,
  rcsd_in_if.sink               in_i,
  rcsd_out_if.source            out_o
);

  localparam int unsigned SLOT_W = $clog2(TABLE_DEPTH);
  localparam int unsigned SH     = CSID_W + SLOT_W;
  localparam int unsigned PW     = CSID_W + SH;
  localparam logic [SH-1:0] RECIP = SH'((64'd1 << SH) / TABLE_DEPTH);

  phase_e            phase_q, phase_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CSID_W-1:0] csid_q, csid_d;
  fmt_e              fmt_q, fmt_d;
  logic [LEN_W-1:0]  hts_q, hts_d, hlen_q, hlen_d;
  logic [7:0]        htype_q, htype_d;
  logic [31:0]       hmsid_q, hmsid_d;
  logic [LEN_W-1:0]  active_q, active_d;
  logic [LEN_W-1:0]  left_q, left_d;
  logic [CAP_W-1:0]  cap_q, cap_d;

  logic              out_vld_q, out_vld_d;
  logic              o_pv_q, o_last_q, o_fold_q;
  logic [7:0]        o_byte_q;
  logic [CSID_W-1:0] o_csid_q;
  ctx_t              o_ctx_q;

  logic              acc, out_free, go, emit, emit_pv, emit_last;
  logic [7:0]        b;
  ctx_ctl_t          ctl;
  ctx_t              ctx_cur, upd_ctx;
  logic              busy;
  logic [CSID_W-1:0] sw_csid;
  logic [PW-1:0]     prod;
  logic [CSID_W-1:0] quo;
  logic [CSID_W:0]   rem;
  logic [SLOT_W-1:0] slot;
  begin_res_t        br;
  logic [3:0]        n;

  assign b        = in_i.in_byte;
  assign out_free = !out_vld_q || out_o.ready;
  assign in_i.ready = !busy && (phase_q != PH_BEGIN) && out_free;
  assign acc      = in_i.valid && in_i.ready;
  assign go       = (phase_q == PH_BEGIN) && out_free;

  // Fold the stream id into the table: reciprocal multiply and one correction.
  always_comb begin
    prod = PW'(sw_csid) * PW'(RECIP);
    quo  = prod[PW-1:SH];
    rem  = {1'b0, sw_csid} - ((CSID_W+1)'(quo) * (CSID_W+1)'(TABLE_DEPTH));
    if (rem >= (CSID_W+1)'(TABLE_DEPTH)) begin
      rem = rem - (CSID_W+1)'(TABLE_DEPTH);
    end
    slot = rem[SLOT_W-1:0];
  end

  // Parser.
  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    csid_d    = csid_q;
    fmt_d     = fmt_q;
    hts_d     = hts_q;
    hlen_d    = hlen_q;
    htype_d   = htype_q;
    hmsid_d   = hmsid_q;
    active_d  = active_q;
    left_d    = left_q;
    cap_d     = cap_q;
    sw_csid   = csid_q;
    ctl       = '0;
    upd_ctx   = ctx_cur;
    emit      = 1'b0;
    emit_pv   = 1'b0;
    emit_last = 1'b0;
    br        = '0;
    n         = cnt_q[3:0];

    if (acc || go) begin
      unique case (phase_q)
        PH_VER: begin
          phase_d = PH_C1;
          cnt_d   = '0;
        end
        PH_C1, PH_C2: begin
          cnt_d = cnt_q + 1'b1;
          if (cnt_d >= HS_BLOCK) begin
            cnt_d   = '0;
            phase_d = (phase_q == PH_C1) ? PH_C2 : PH_BASIC;
          end
        end
        PH_CSID: begin
          if (csid_q == '0) begin
            sw_csid = CSID_W'(b) + CSID_OFS;
            ctl.sw  = 1'b1;
          end else if (cnt_q == '0) begin
            hts_d = LEN_W'(b);
            cnt_d = CNT_W'(1);
          end else begin
            sw_csid = CSID_W'(hts_q[7:0]) + {1'b0, b, 8'h00} + CSID_OFS;
            ctl.sw  = 1'b1;
          end
        end
        PH_MSG: begin
          if (n < 4'd3) begin
            hts_d = {hts_q[LEN_W-9:0], b};
          end else if (n < 4'd6) begin
            hlen_d = {hlen_q[LEN_W-9:0], b};
          end else if (n == 4'd6) begin
            htype_d = b;
          end else begin
            hmsid_d = hmsid_q | (32'(b) << {n[1:0] + 2'd1, 3'b000});
          end
          cnt_d = cnt_q + 1'b1;
          if (cnt_d[3:0] >= hdr_len(fmt_q)) begin
            br = begin_chunk(ctx_cur, fmt_q, hts_d, hlen_d, htype_d, hmsid_d, active_q);
          end
        end
        PH_BEGIN: begin
          br = begin_chunk(ctx_cur, fmt_q, hts_q, hlen_q, htype_q, hmsid_q, active_q);
        end
        PH_PAY: begin
          upd_ctx = ctx_cur;
          ctl.upd = 1'b1;
          emit    = 1'b1;
          emit_pv = 1'b1;
          if (ctx_cur.typ == TYPE_SET_CHUNK) begin
            if (ctx_cur.rcvd == '0) begin
              cap_d = '0;
            end
            if (ctx_cur.rcvd < LEN_W'(4)) begin
              cap_d = {cap_d[CAP_W-9:0], b};
            end
          end
          upd_ctx.rcvd = ctx_cur.rcvd + 1'b1;
          left_d       = left_q - 1'b1;
          if (upd_ctx.rcvd >= ctx_cur.len) begin
            emit_last    = 1'b1;
            upd_ctx.rcvd = '0;
            if (ctx_cur.typ == TYPE_SET_CHUNK && cap_d != '0) begin
              active_d = (cap_d > CAP_W'(LEN_MAX)) ? LEN_MAX : cap_d[LEN_W-1:0];
            end
            phase_d = PH_BASIC;
            cnt_d   = '0;
          end else if (left_d == '0) begin
            phase_d = PH_BASIC;
            cnt_d   = '0;
          end
        end
        default: begin
          fmt_d  = fmt_e'(b[7:6]);
          csid_d = CSID_W'(b[5:0]);
          cnt_d  = '0;
          if (b[5:1] == '0) begin
            phase_d = PH_CSID;
          end else begin
            sw_csid = CSID_W'(b[5:0]);
            ctl.sw  = 1'b1;
          end
        end
      endcase

      // End of the basic header: fetch the stream and start the message header, or go to the BEGIN phase for format 3.
      if (ctl.sw) begin
        csid_d  = sw_csid;
        cnt_d   = '0;
        hts_d   = '0;
        hlen_d  = '0;
        htype_d = '0;
        hmsid_d = '0;
        phase_d = (fmt_d == FMT_NONE) ? PH_BEGIN : PH_MSG;
      end

      // Header complete: apply it to the context and open the chunk, or end an empty message.
      if ((phase_q == PH_BEGIN) ||
          ((phase_q == PH_MSG) && (cnt_d[3:0] >= hdr_len(fmt_q)))) begin
        upd_ctx = br.ctx;
        ctl.upd = 1'b1;
        cnt_d   = '0;
        if (br.empty) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          phase_d   = PH_BASIC;
        end else begin
          left_d  = br.left;
          phase_d = PH_PAY;
        end
      end
    end

    // Register write, for the user only while the block is idle; the block itself does not enforce this.
    if (cfg_we_i) begin
      active_d = (cfg_data_i == '0) ? LEN_W'(1) : cfg_data_i;
    end
  end

  rcsd_ctx_store #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctx_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .slot_i    (slot),
    .upd_ctx_i (upd_ctx),
    .ctx_o     (ctx_cur),
    .busy_o    (busy)
  );

  assign out_vld_d = emit ? 1'b1 : (out_o.ready ? 1'b0 : out_vld_q);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_VER;
      cnt_q     <= '0;
      csid_q    <= '0;
      fmt_q     <= FMT_FULL;
      hts_q     <= '0;
      hlen_q    <= '0;
      htype_q   <= '0;
      hmsid_q   <= '0;
      active_q  <= CHUNK_RST;
      left_q    <= '0;
      cap_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      csid_q    <= csid_d;
      fmt_q     <= fmt_d;
      hts_q     <= hts_d;
      hlen_q    <= hlen_d;
      htype_q   <= htype_d;
      hmsid_q   <= hmsid_d;
      active_q  <= active_d;
      left_q    <= left_d;
      cap_q     <= cap_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      o_pv_q   <= emit_pv;
      o_byte_q <= emit_pv ? b : 8'h00;
      o_csid_q <= csid_q;
      o_ctx_q  <= upd_ctx;
      o_last_q <= emit_last;
      o_fold_q <= ({1'b0, csid_q} >= (CSID_W+1)'(TABLE_DEPTH));
    end
  end

  assign out_o.valid             = out_vld_q;
  assign out_o.payload_valid     = o_pv_q;
  assign out_o.payload_byte      = o_byte_q;
  assign out_o.chunk_stream_id   = o_csid_q;
  assign out_o.message_type      = o_ctx_q.typ;
  assign out_o.message_timestamp = o_ctx_q.ts;
  assign out_o.msg_stream_id     = o_ctx_q.msid;
  assign out_o.msg_length        = o_ctx_q.len;
  assign out_o.last_of_message   = o_last_q;
  assign out_o.stream_folded     = o_fold_q;

  // A chunk in progress always has payload left to read.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (phase_q == PH_PAY) |-> (left_q != '0))
    else $error("payload phase with nothing left");
  // Every accepted payload byte leaves a result in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (acc && (phase_q == PH_PAY)) |=> (out_vld_q && o_pv_q))
    else $error("payload byte lost");
  // A result is never overwritten before it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni) emit |-> out_free)
    else $error("result overwritten");

endmodule

`default_nettype wire

>>> tb/tb_rtmp_chunk_demux_unit.sv
// Self-checking testbench of the chunk stream demultiplexer: handshake skip, chunk headers,
// per-stream context, set-chunk-size and folded csids, compared against an inline predictor.
// Depends on rcsd_pkg, rcsd_if and rtmp_chunk_demux_unit.
`timescale 1ns / 1ps

module tb_rtmp_chunk_demux_unit import rcsd_pkg::*;;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD = 300;

  // One expected tagged byte or empty-message end.
  typedef struct packed {
    logic              pvalid;
    logic [7:0]        pbyte;
    logic [CSID_W-1:0] csid;
    logic [7:0]        mtype;
    logic [TS_W-1:0]   mts;
    logic [31:0]       msid;
    logic [LEN_W-1:0]  mlen;
    logic              last;
    logic              folded;
  } tagged_byte_t;

  // Parser phases of the predictor.
  typedef enum logic [2:0] {
    P_VER, P_C1, P_C2, P_BASIC, P_CSID, P_MSG, P_PAY
  } pred_phase_e;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [LEN_W-1:0] cfg_data_i;

  rcsd_in_if  in_ch ();
  rcsd_out_if out_ch ();

  rtmp_chunk_demux_unit #(.TABLE_DEPTH(DEPTH)) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_ch),
    .out_o     (out_ch)
  );

  // Predictor state.
  pred_phase_e       ph;
  int unsigned       pcount;
  logic [CSID_W-1:0] cur_csid;
  logic [1:0]        cur_fmt;
  logic [LEN_W-1:0]  h_ts, h_len;
  logic [7:0]        h_type;
  logic [31:0]       h_msid;
  logic [LEN_W-1:0]  pred_csize, bytes_left;
  logic [31:0]       size_capture;
  logic [TS_W-1:0]   s_ts [DEPTH];
  logic [LEN_W-1:0]  s_delta [DEPTH];
  logic [LEN_W-1:0]  s_len [DEPTH];
  logic [7:0]        s_type [DEPTH];
  logic [31:0]       s_msid [DEPTH];
  logic [LEN_W-1:0]  s_rcvd [DEPTH];

  tagged_byte_t expected_bytes[$];
  logic [7:0]   pending_bytes[$];

  int  mismatches;
  int  idle_cycles;
  bit  drive_idle_enable;
  bit  hold_sink;
  bit  hold_taken;
  int  long_hold;
  bit  timed_out;

  function automatic int unsigned hdr_bytes(logic [1:0] f);
    case (fmt_e'(f))
      FMT_FULL:  return 11;
      FMT_NOSID: return 7;
      FMT_TS:    return 3;
      default:   return 0;
    endcase
  endfunction

  function automatic void push_tagged(logic v, logic [7:0] b, logic l);
    tagged_byte_t t;
    int unsigned i;
    i = cur_csid % DEPTH;
    t.pvalid = v; t.pbyte = b; t.csid = cur_csid; t.mtype = s_type[i];
    t.mts = s_ts[i]; t.msid = s_msid[i]; t.mlen = s_len[i]; t.last = l;
    t.folded = (cur_csid >= DEPTH);
    expected_bytes.insert(expected_bytes.size(), t);
  endfunction

  function automatic void reset_model();
    ph = P_VER; pcount = 0; cur_csid = '0; cur_fmt = '0;
    h_ts = '0; h_len = '0; h_type = '0; h_msid = '0;
    pred_csize = CHUNK_RST; bytes_left = '0; size_capture = '0;
    for (int k = 0; k < DEPTH; k++) begin
      s_ts[k] = '0; s_delta[k] = '0; s_len[k] = '0;
      s_type[k] = '0; s_msid[k] = '0; s_rcvd[k] = '0;
    end
  endfunction

  function automatic void set_chunk_size(logic [LEN_W-1:0] v);
    pred_csize = (v == '0) ? 24'd1 : v;
  endfunction

  // Applies a finished header to the stream context; may end an empty message.
  function automatic void start_chunk();
    int unsigned i;
    logic [LEN_W-1:0] rl;
    i = cur_csid % DEPTH;
    case (fmt_e'(cur_fmt))
      FMT_FULL: begin
        s_ts[i] = TS_W'(h_ts); s_len[i] = h_len; s_type[i] = h_type; s_msid[i] = h_msid;
      end
      FMT_NOSID: begin
        s_delta[i] = h_ts; s_ts[i] += TS_W'(h_ts); s_len[i] = h_len; s_type[i] = h_type;
      end
      FMT_TS: begin
        s_delta[i] = h_ts; s_ts[i] += TS_W'(h_ts);
      end
      default: begin
        if (s_rcvd[i] == '0) s_ts[i] += TS_W'(s_delta[i]);
      end
    endcase
    pcount = 0;
    if (s_rcvd[i] >= s_len[i]) begin
      s_rcvd[i] = '0;
      ph = P_BASIC;
      push_tagged(1'b0, 8'd0, 1'b1);
      return;
    end
    rl = s_len[i] - s_rcvd[i];
    bytes_left = (rl > pred_csize) ? pred_csize : rl;
    ph = P_PAY;
  endfunction

  function automatic void basic_done();
    pcount = 0; h_ts = '0; h_len = '0; h_type = '0; h_msid = '0;
    if (hdr_bytes(cur_fmt) == 0) start_chunk();
    else ph = P_MSG;
  endfunction

  // Advances the predictor by one accepted connection byte.
  function automatic void demux_byte(logic [7:0] b);
    int unsigned i;
    case (ph)
      P_VER: begin
        ph = P_C1; pcount = 0;
      end
      P_C1, P_C2: begin
        pcount++;
        if (pcount >= 1536) begin
          pcount = 0;
          ph = (ph == P_C1) ? P_C2 : P_BASIC;
        end
      end
      P_CSID: begin
        if (cur_csid == '0) begin
          cur_csid = CSID_W'(b) + CSID_OFS;
          basic_done();
        end else if (pcount == 0) begin
          h_ts = LEN_W'(b); pcount = 1;
        end else begin
          cur_csid = CSID_W'(h_ts[7:0]) + (CSID_W'(b) << 8) + CSID_OFS;
          basic_done();
        end
      end
      P_MSG: begin
        if (pcount < 3) h_ts = {h_ts[15:0], b};
        else if (pcount < 6) h_len = {h_len[15:0], b};
        else if (pcount == 6) h_type = b;
        else if (pcount < 11) h_msid |= 32'(b) << (8 * (pcount - 7));
        pcount++;
        if (pcount >= hdr_bytes(cur_fmt)) start_chunk();
      end
      P_PAY: begin
        i = cur_csid % DEPTH;
        if (s_type[i] == TYPE_SET_CHUNK) begin
          if (s_rcvd[i] == '0) size_capture = '0;
          if (s_rcvd[i] < 4) size_capture = {size_capture[23:0], b};
        end
        s_rcvd[i] = s_rcvd[i] + 1'b1;
        bytes_left = bytes_left - 1'b1;
        if (s_rcvd[i] >= s_len[i]) begin
          push_tagged(1'b1, b, 1'b1);
          s_rcvd[i] = '0;
          if (s_type[i] == TYPE_SET_CHUNK && size_capture != '0)
            pred_csize = (size_capture > 32'hFFFFFF) ? LEN_MAX : size_capture[23:0];
          ph = P_BASIC; pcount = 0;
        end else begin
          if (bytes_left == '0) begin
            ph = P_BASIC; pcount = 0;
          end
          push_tagged(1'b1, b, 1'b0);
        end
      end
      default: begin
        cur_fmt = b[7:6];
        cur_csid = CSID_W'(b[5:0]);
        pcount = 0;
        if (cur_csid <= 1) ph = P_CSID;
        else basic_done();
      end
    endcase
  endfunction

  // Appends one byte to the stimulus queue.
  function automatic void queue_byte(logic [7:0] v);
    pending_bytes.insert(pending_bytes.size(), v);
  endfunction

  // Stimulus helpers: each call queues header or payload bytes into the pending bytes.
  function automatic void add_basic(logic [1:0] f, int unsigned id);
    if (id < 64) begin
      queue_byte({f, id[5:0]});
    end else if (id < 320) begin
      queue_byte({f, 6'd0});
      queue_byte(8'(id - 64));
    end else begin
      queue_byte({f, 6'd1});
      queue_byte(8'(id - 64));
      queue_byte(8'((id - 64) >> 8));
    end
  endfunction

  function automatic void add_header(logic [1:0] f, int unsigned id, logic [23:0] ts,
                                     logic [23:0] len, logic [7:0] typ, logic [31:0] sid);
    add_basic(f, id);
    if (hdr_bytes(f) >= 3) begin
      queue_byte(ts[23:16]);
      queue_byte(ts[15:8]);
      queue_byte(ts[7:0]);
    end
    if (hdr_bytes(f) >= 7) begin
      queue_byte(len[23:16]);
      queue_byte(len[15:8]);
      queue_byte(len[7:0]);
      queue_byte(typ);
    end
    if (hdr_bytes(f) == 11) begin
      for (int k = 0; k < 4; k++) queue_byte(sid[8*k +: 8]);
    end
  endfunction

  function automatic void add_payload(int unsigned n);
    for (int k = 0; k < n; k++) queue_byte(8'($urandom));
  endfunction

  // Sends a message of len bytes cut at csize, with fmt 3 continuations.
  function automatic void add_message(logic [1:0] f, int unsigned id, logic [23:0] ts,
                                      int unsigned len, logic [7:0] typ, logic [31:0] sid,
                                      int unsigned csize);
    int unsigned sent;
    add_header(f, id, ts, 24'(len), typ, sid);
    sent = (len < csize) ? len : csize;
    add_payload(sent);
    while (sent < len) begin
      add_basic(2'd3, id);
      add_payload((len - sent < csize) ? len - sent : csize);
      sent += (len - sent < csize) ? len - sent : csize;
    end
  endfunction

  function automatic int unsigned pick_csid();
    case ($urandom_range(0, 5))
      0: return $urandom_range(2, 5);
      1: return $urandom_range(2, 63);
      2: return $urandom_range(64, 319);
      3: return $urandom_range(320, 65599);
      4: return 65599;
      default: return $urandom_range(2, 9);
    endcase
  endfunction

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Input driver: offers the oldest pending byte, with random idle bursts when enabled.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.in_byte <= '0;
      idle_cycles <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        demux_byte(in_ch.in_byte);
        pending_bytes.delete(0);
      end
      if (idle_cycles > 0) begin
        idle_cycles <= idle_cycles - 1;
        in_ch.valid <= 1'b0;
      end else if (drive_idle_enable && $urandom_range(0, 19) == 0 &&
                   !(in_ch.valid && !in_ch.ready)) begin
        idle_cycles <= $urandom_range(1, 16) - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.in_byte <= pending_bytes[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Output sink: ready with random stall bursts when enabled and one long hold timed here.
  int stall_cycles;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      stall_cycles <= 0;
      long_hold <= 0;
      hold_taken <= 1'b0;
    end else if (hold_sink && !hold_taken) begin
      hold_taken <= 1'b1;
      long_hold <= LONG_HOLD - 1;
      out_ch.ready <= 1'b0;
    end else if (long_hold > 0) begin
      long_hold <= long_hold - 1;
      out_ch.ready <= 1'b0;
    end else if (stall_cycles > 0) begin
      stall_cycles <= stall_cycles - 1;
      out_ch.ready <= 1'b0;
    end else if (drive_idle_enable && $urandom_range(0, 19) == 0) begin
      stall_cycles <= $urandom_range(1, 16) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Monitor: compares each output transfer with the oldest expectation.
  always @(posedge clk_i) begin
    tagged_byte_t want, got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.pvalid = out_ch.payload_valid; got.pbyte = out_ch.payload_byte;
      got.csid = out_ch.chunk_stream_id; got.mtype = out_ch.message_type;
      got.mts = out_ch.message_timestamp; got.msid = out_ch.msg_stream_id;
      got.mlen = out_ch.msg_length; got.last = out_ch.last_of_message;
      got.folded = out_ch.stream_folded;
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected output transfer: %p", got);
      end else begin
        want = expected_bytes[0];
        expected_bytes.delete(0);
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // Watchdog: counts cycles without any transfer.
  int quiet_cycles;
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out) begin
        timed_out = 1'b1;
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || expected_bytes.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_chunk_size(logic [LEN_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    set_chunk_size(v);
  endtask

  // Random traffic: mostly well-formed messages, some noise headers.
  task automatic random_phase(int unsigned n_bytes, int unsigned csize);
    int unsigned goal;
    int unsigned id;
    goal = pending_bytes.size() + n_bytes;
    while (pending_bytes.size() < goal) begin
      id = pick_csid();
      case ($urandom_range(0, 9))
        0: add_message(2'd1, id, 24'($urandom), $urandom_range(0, 40), 8'($urandom),
                       0, csize);
        1: add_message(2'd2, id, 24'($urandom), $urandom_range(0, 3), 0, 0, csize);
        2: begin
          add_basic(2'd3, id);
        end
        3: add_message(2'd0, id, 24'hFFFFFF, 0, 8'd9, $urandom, csize);
        default: add_message(2'd0, id, 24'($urandom), $urandom_range(1, 30),
                             8'($urandom_range(2, 255)), $urandom, csize);
      endcase
    end
    while (pending_bytes.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    drive_idle_enable = 1'b1;
    hold_sink = 1'b0;
    mismatches = 0;
    timed_out = 1'b0;
    reset_model();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_chunk_size(24'd0);
    write_chunk_size(24'd16);

    // Handshake: version byte then two 1536-byte blocks, all random.
    add_payload(1 + 2 * 1536);

    // Directed chunks: each header form, empty messages, extremes, set chunk size.
    add_message(2'd0, 2, 24'hFFFFFF, 20, 8'd8, 32'hFFFFFFFF, 16);
    add_message(2'd0, 64, 24'd0, 0, 8'd0, 32'h0, 16);
    add_message(2'd1, 319, 24'h000010, 3, 8'hFF, 0, 16);
    add_message(2'd0, 65599, 24'h123456, 2, 8'd18, 32'h01020304, 16);
    add_message(2'd2, 65599, 24'h000001, 2, 0, 0, 16);
    add_message(2'd0, 3, 24'd5, 4, 8'd1, 0, 16);
    pending_bytes[pending_bytes.size()-4] = 8'h00;
    pending_bytes[pending_bytes.size()-3] = 8'h00;
    pending_bytes[pending_bytes.size()-2] = 8'h00;
    pending_bytes[pending_bytes.size()-1] = 8'h08;
    add_message(2'd0, 4, 24'd0, 20, 8'd9, 0, 8);
    while (pending_bytes.size() != 0) @(posedge clk_i);

    // Long receiver hold while the sender keeps offering.
    hold_sink = 1'b1;
    add_message(2'd0, 5, 24'd7, 30, 8'd9, 32'h55, 8);
    wait_drained();

    write_chunk_size(24'hFFFFFF);
    random_phase(700, 24'hFFFFFF);
    wait_drained();

    write_chunk_size(24'd1);
    random_phase(500, 1);
    wait_drained();

    write_chunk_size(24'd7);
    drive_idle_enable = 1'b0;
    random_phase(500, 7);
    wait_drained();

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
